// ===== src/assert_macros.svh =====
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a same-cycle implication on every clock edge outside reset.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication in the next cycle on every clock edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/imm_pkg.sv =====
`default_nettype none

package imm_pkg;

  // Width of one limb on the ports
  localparam int WORD_BITS = 32;

  // One input transfer: a limb of each operand
  typedef struct packed {
    logic [WORD_BITS-1:0] a_word;
    logic [WORD_BITS-1:0] b_word;
    logic [WORD_BITS-1:0] modulus_word;
    logic                 final_limb;
  } in_item_t;

  // One result transfer
  typedef struct packed {
    logic [WORD_BITS-1:0] product_word;
    logic                 product_last;
  } out_item_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_we;   // store the input limbs at idx
    logic init;      // clear accumulator and flags for a new run
    logic b_rd;      // read a multiplier limb at idx
    logic b_latch;   // take the multiplier limb into the bit shifter
    logic pass_rd;   // read operand limbs at idx for a limb pass
    logic calc;      // process the limb read in the previous cycle
    logic first;     // that limb is the least significant one
    logic commit;    // end of a bit step: pick reduced copies, shift b
    logic out_rd;    // read an accumulator limb at idx for output
    logic out_last;  // that limb is the most significant one
  } cmd_t;

endpackage

`default_nettype wire

// ===== src/imm_ram.sv =====
`default_nettype none

module imm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/imm_ctrl.sv =====
`default_nettype none

module imm_ctrl #(
  parameter int LIMBS     = 32,
  parameter int LIMB_BITS = 32,
  localparam int IW = (LIMBS > 1) ? $clog2(LIMBS) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic          final_i,
  output logic               busy_o,
  output imm_pkg::cmd_t      cmd_o,
  output logic [IW-1:0]      idx_o
);

  localparam int CW = $clog2(LIMBS + 1);
  localparam int BW = $clog2(LIMB_BITS);
  localparam logic [CW-1:0] LIMBS_C = CW'(LIMBS);
  localparam logic [BW-1:0] LAST_BIT = BW'(LIMB_BITS - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FETCH = 3'd1;
  localparam logic [2:0] ST_LATCH = 3'd2;
  localparam logic [2:0] ST_START = 3'd3;
  localparam logic [2:0] ST_PASS  = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] lcnt_q, lcnt_d;
  logic [CW-1:0] n_q, n_d;
  logic [IW-1:0] blimb_q, blimb_d;
  logic [BW-1:0] bpos_q, bpos_d;
  logic [IW-1:0] i_q, i_d;
  logic [CW-1:0] i_next;
  logic [CW-1:0] blimb_next;

  assign i_next     = CW'(i_q) + CW'(1);
  assign blimb_next = CW'(blimb_q) + CW'(1);

  // Sequence loads, bit steps, limb passes and output
  always_comb begin
    state_d = state_q;
    lcnt_d  = lcnt_q;
    n_d     = n_q;
    blimb_d = blimb_q;
    bpos_d  = bpos_q;
    i_d     = i_q;
    cmd_o   = '0;
    idx_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          idx_o = lcnt_q[IW-1:0];
          if (lcnt_q < LIMBS_C) begin
            cmd_o.load_we = 1'b1;
            lcnt_d = lcnt_q + CW'(1);
          end
          if (final_i) begin
            cmd_o.init = 1'b1;
            n_d     = lcnt_d;
            lcnt_d  = '0;
            blimb_d = '0;
            state_d = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        cmd_o.b_rd = 1'b1;
        idx_o = blimb_q;
        state_d = ST_LATCH;
      end
      ST_LATCH: begin
        cmd_o.b_latch = 1'b1;
        bpos_d  = '0;
        state_d = ST_START;
      end
      ST_START: begin
        cmd_o.pass_rd = 1'b1;
        idx_o = '0;
        i_d = '0;
        state_d = ST_PASS;
      end
      ST_PASS: begin
        cmd_o.calc  = 1'b1;
        cmd_o.first = (i_q == '0);
        if (i_next < n_q) begin
          cmd_o.pass_rd = 1'b1;
          idx_o = i_next[IW-1:0];
          i_d = i_next[IW-1:0];
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.commit = 1'b1;
        i_d = '0;
        if (bpos_q == LAST_BIT) begin
          bpos_d = '0;
          if (blimb_next == n_q) begin
            state_d = ST_OUT;
          end else begin
            blimb_d = blimb_next[IW-1:0];
            state_d = ST_FETCH;
          end
        end else begin
          bpos_d  = bpos_q + BW'(1);
          state_d = ST_START;
        end
      end
      ST_OUT: begin
        cmd_o.out_rd   = 1'b1;
        cmd_o.out_last = (i_next == n_q);
        idx_o = i_q;
        if (i_next == n_q) begin
          state_d = ST_IDLE;
        end else begin
          i_d = i_next[IW-1:0];
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lcnt_q  <= '0;
      n_q     <= '0;
      blimb_q <= '0;
      bpos_q  <= '0;
      i_q     <= '0;
    end else begin
      state_q <= state_d;
      lcnt_q  <= lcnt_d;
      n_q     <= n_d;
      blimb_q <= blimb_d;
      bpos_q  <= bpos_d;
      i_q     <= i_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

// ===== src/imm_datapath.sv =====
`default_nettype none

module imm_datapath #(
  parameter int LIMBS     = 32,
  parameter int LIMB_BITS = 32,
  localparam int IW = (LIMBS > 1) ? $clog2(LIMBS) : 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire imm_pkg::cmd_t      cmd_i,
  input  wire logic [IW-1:0]      idx_i,
  input  wire imm_pkg::in_item_t  item_i,
  output logic                    res_valid_o,
  output imm_pkg::out_item_t      res_o
);

  localparam int W  = LIMB_BITS;
  localparam int EW = (LIMB_BITS > imm_pkg::WORD_BITS) ? LIMB_BITS : imm_pkg::WORD_BITS;

  // Operand limbs from the port, fitted to the limb width
  logic [EW-1:0] in_a_ext, in_b_ext, in_n_ext;
  logic [W-1:0]  in_a, in_b, in_n;

  assign in_a_ext = EW'(item_i.a_word);
  assign in_b_ext = EW'(item_i.b_word);
  assign in_n_ext = EW'(item_i.modulus_word);
  assign in_a = in_a_ext[W-1:0];
  assign in_b = in_b_ext[W-1:0];
  assign in_n = in_n_ext[W-1:0];

  // Two copies each of a and the accumulator: plain and minus N
  logic [W-1:0] a0_rd, a1_rd, c0_rd, c1_rd, b_rd, n_rd;
  logic         a0_we;
  logic [IW-1:0] a0_waddr;
  logic [W-1:0]  a0_wdata;
  logic          c_we;
  logic          c_re;
  logic [W-1:0]  sc, dc, da, ea;

  logic          a_sel_q, c_sel_q, c_zero_q, a_ovf_q, c_ovf_q, ov_q;
  logic          add_c_q, bor_c_q, dbl_q, bor_a_q, ol_q;
  logic [W-1:0]  b_reg_q;
  logic [IW-1:0] wr_idx_q;

  assign a0_we    = cmd_i.load_we | cmd_i.calc;
  assign a0_waddr = cmd_i.load_we ? idx_i : wr_idx_q;
  assign a0_wdata = cmd_i.load_we ? in_a : da;
  assign c_we     = cmd_i.calc & b_reg_q[0];
  assign c_re     = cmd_i.pass_rd | cmd_i.out_rd;

  imm_ram #(.WIDTH(W), .DEPTH(LIMBS)) u_a0 (
    .clk_i, .we_i(a0_we), .waddr_i(a0_waddr), .wdata_i(a0_wdata),
    .re_i(cmd_i.pass_rd), .raddr_i(idx_i), .rdata_o(a0_rd)
  );
  imm_ram #(.WIDTH(W), .DEPTH(LIMBS)) u_a1 (
    .clk_i, .we_i(cmd_i.calc), .waddr_i(wr_idx_q), .wdata_i(ea),
    .re_i(cmd_i.pass_rd), .raddr_i(idx_i), .rdata_o(a1_rd)
  );
  imm_ram #(.WIDTH(W), .DEPTH(LIMBS)) u_c0 (
    .clk_i, .we_i(c_we), .waddr_i(wr_idx_q), .wdata_i(sc),
    .re_i(c_re), .raddr_i(idx_i), .rdata_o(c0_rd)
  );
  imm_ram #(.WIDTH(W), .DEPTH(LIMBS)) u_c1 (
    .clk_i, .we_i(c_we), .waddr_i(wr_idx_q), .wdata_i(dc),
    .re_i(c_re), .raddr_i(idx_i), .rdata_o(c1_rd)
  );
  imm_ram #(.WIDTH(W), .DEPTH(LIMBS)) u_b (
    .clk_i, .we_i(cmd_i.load_we), .waddr_i(idx_i), .wdata_i(in_b),
    .re_i(cmd_i.b_rd), .raddr_i(idx_i), .rdata_o(b_rd)
  );
  imm_ram #(.WIDTH(W), .DEPTH(LIMBS)) u_n (
    .clk_i, .we_i(cmd_i.load_we), .waddr_i(idx_i), .wdata_i(in_n),
    .re_i(cmd_i.pass_rd), .raddr_i(idx_i), .rdata_o(n_rd)
  );

  // Limb step: add a into acc, double a, subtract N from both
  logic [W-1:0] x_a, x_c;
  logic         cin, bin_c, din, bin_a;
  logic [W:0]   sum_c, diff_c, diff_a;

  assign x_a   = a_sel_q ? a1_rd : a0_rd;
  assign x_c   = c_zero_q ? '0 : (c_sel_q ? c1_rd : c0_rd);
  assign cin   = cmd_i.first ? 1'b0 : add_c_q;
  assign bin_c = cmd_i.first ? 1'b0 : bor_c_q;
  assign din   = cmd_i.first ? 1'b0 : dbl_q;
  assign bin_a = cmd_i.first ? 1'b0 : bor_a_q;

  assign sum_c  = {1'b0, x_c} + {1'b0, x_a} + (W+1)'(cin);
  assign sc     = sum_c[W-1:0];
  assign diff_c = {1'b0, sc} - {1'b0, n_rd} - (W+1)'(bin_c);
  assign dc     = diff_c[W-1:0];
  assign da     = {x_a[W-2:0], din};
  assign diff_a = {1'b0, da} - {1'b0, n_rd} - (W+1)'(bin_a);
  assign ea     = diff_a[W-1:0];

  // Bit-step decisions from the final carries and borrows
  logic so, ge_c, c_ovf_new, ge_a, a_ovf_new;

  assign so        = c_ovf_q ^ a_ovf_q ^ add_c_q;
  assign ge_c      = so | ~bor_c_q;
  assign c_ovf_new = so ^ (ge_c & bor_c_q);
  assign ge_a      = dbl_q | ~bor_a_q;
  assign a_ovf_new = dbl_q ^ (ge_a & bor_a_q);

  // Track copy selects, overflow bits and the output strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_sel_q  <= 1'b0;
      c_sel_q  <= 1'b0;
      c_zero_q <= 1'b1;
      a_ovf_q  <= 1'b0;
      c_ovf_q  <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      ov_q <= cmd_i.out_rd;
      if (cmd_i.init) begin
        a_sel_q  <= 1'b0;
        c_sel_q  <= 1'b0;
        c_zero_q <= 1'b1;
        a_ovf_q  <= 1'b0;
        c_ovf_q  <= 1'b0;
      end else if (cmd_i.commit) begin
        a_sel_q <= ge_a;
        a_ovf_q <= a_ovf_new;
        if (b_reg_q[0]) begin
          c_sel_q  <= ge_c;
          c_ovf_q  <= c_ovf_new;
          c_zero_q <= 1'b0;
        end
      end
    end
  end

  // Hold chain carries, write index and the multiplier bits
  always_ff @(posedge clk_i) begin
    ol_q <= cmd_i.out_last;
    if (cmd_i.pass_rd) begin
      wr_idx_q <= idx_i;
    end
    if (cmd_i.calc) begin
      add_c_q <= sum_c[W];
      bor_c_q <= diff_c[W];
      dbl_q   <= x_a[W-1];
      bor_a_q <= diff_a[W];
    end
    if (cmd_i.b_latch) begin
      b_reg_q <= b_rd;
    end else if (cmd_i.commit) begin
      b_reg_q <= b_reg_q >> 1;
    end
  end

  // Present the accumulator limb read in the previous cycle
  logic [EW-1:0] res_ext;

  assign res_ext            = EW'(x_c);
  assign res_valid_o        = ov_q;
  assign res_o.product_word = res_ext[imm_pkg::WORD_BITS-1:0];
  assign res_o.product_last = ol_q;

endmodule

`default_nettype wire

// ===== src/interleaved_modular_multiplier_unit.sv =====
// Channel   | Ports                              | Transfer
// ----------+------------------------------------+----------------------------------
// operands  | start, busy, item_i (in_item_t)    | edge with start high, busy low
// result    | product_valid_o, product_o         | every edge with product_valid_o
//
// A limb that is not the last one is stored and leaves the unit idle. The last
// limb starts the run: n*LIMB_BITS bit steps, each a limb-serial add and
// subtract pass over the RAMs, with a multiplier limb fetch before every LIMB_BITS
// steps, then n result limbs, one limb per cycle.
// Reset clears control only; the operand RAMs need no clearing pass.
// Results are shown for one cycle each and cannot be held off.
`default_nettype none

module interleaved_modular_multiplier_unit #(
  parameter int LIMBS     = 32,
  parameter int LIMB_BITS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire imm_pkg::in_item_t  item_i,
  output logic                    product_valid_o,
  output imm_pkg::out_item_t      product_o
);

  localparam int IW = (LIMBS > 1) ? $clog2(LIMBS) : 1;

  imm_pkg::cmd_t  cmd;
  logic [IW-1:0]  idx;

  imm_ctrl #(.LIMBS(LIMBS), .LIMB_BITS(LIMB_BITS)) u_ctrl (
    .clk_i,
    .rst_ni,
    .start_i (start),
    .final_i (item_i.final_limb),
    .busy_o  (busy),
    .cmd_o   (cmd),
    .idx_o   (idx)
  );

  imm_datapath #(.LIMBS(LIMBS), .LIMB_BITS(LIMB_BITS)) u_datapath (
    .clk_i,
    .rst_ni,
    .cmd_i       (cmd),
    .idx_i       (idx),
    .item_i,
    .res_valid_o (product_valid_o),
    .res_o       (product_o)
  );

endmodule

`default_nettype wire

// ===== src/imm_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module imm_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start,
  input wire logic               busy,
  input wire imm_pkg::in_item_t  item_i,
  input wire logic               product_valid_o,
  input wire imm_pkg::out_item_t product_o
);

  // The unit goes idle exactly when the top result limb shows
  `ASSERT_NOW(a_fall_on_last, clk_i, rst_ni, $fell(busy), product_valid_o && product_o.product_last, "busy fell without the last result")

  // A limb that does not start the run leaves the unit idle in the next cycle
  `ASSERT_NEXT(a_load_one_cycle, clk_i, rst_ni, start && !busy && !item_i.final_limb, !busy, "non-final limb left the unit busy")

  // The final limb starts the run
  `ASSERT_NEXT(a_final_starts, clk_i, rst_ni, start && !busy && item_i.final_limb, busy, "final limb did not start the run")

  // Result limbs follow each other without gaps
  `ASSERT_NEXT(a_results_back_to_back, clk_i, rst_ni, product_valid_o && !product_o.product_last, product_valid_o, "gap inside the result burst")

endmodule

bind interleaved_modular_multiplier_unit imm_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .item_i          (item_i),
  .product_valid_o (product_valid_o),
  .product_o       (product_o)
);

`default_nettype wire

// ===== sim/interleaved_modular_multiplier_unit_test.sv =====
`timescale 1ns / 1ps

module interleaved_modular_multiplier_unit_test;

  localparam int LIMB_MAX = 32;
  localparam int WORD_W = imm_pkg::WORD_BITS;
  localparam int CYCLE_LIMIT = 1_000_000;

  // Operand limbs plus one overflow bit above the top limb
  typedef logic [LIMB_MAX*WORD_W:0] wide_t;

  typedef enum int {
    OPS_BELOW_MOD,
    OPS_RAW,
    OPS_ZERO_MOD,
    OPS_ALL_ONES
  } operand_shape_e;

  // Track loaded limbs and the product limbs that each run should return
  class mod_product_tracker;
    wide_t a_vec;
    wide_t b_vec;
    wide_t m_vec;
    int unsigned loaded;
    int unsigned mismatches;
    imm_pkg::out_item_t expected_limbs[$];

    function new();
      a_vec = '0;
      b_vec = '0;
      m_vec = '0;
      loaded = 0;
      mismatches = 0;
    endfunction

    // Subtract the modulus once if the full value reaches it
    function wide_t reduce_once(wide_t x, wide_t m, wide_t mask);
      if (x >= m) begin
        return (x - m) & mask;
      end
      return x;
    endfunction

    // Store one accepted limb; on the last one, run the interleaved product
    function void note_limb(imm_pkg::in_item_t it);
      wide_t mask;
      wide_t low_mask;
      wide_t acc;
      wide_t mcand;
      wide_t mplier;
      wide_t modulus;
      imm_pkg::out_item_t e;
      int unsigned n;
      if (loaded < LIMB_MAX) begin
        a_vec[loaded*WORD_W +: WORD_W] = it.a_word;
        b_vec[loaded*WORD_W +: WORD_W] = it.b_word;
        m_vec[loaded*WORD_W +: WORD_W] = it.modulus_word;
        loaded++;
      end
      if (!it.final_limb) begin
        return;
      end
      n = loaded;
      mask = (wide_t'(1) << (n*WORD_W + 1)) - 1;
      low_mask = (wide_t'(1) << (n*WORD_W)) - 1;
      mcand = a_vec & low_mask;
      mplier = b_vec & low_mask;
      modulus = m_vec & low_mask;
      acc = '0;
      for (int k = 0; k < n*WORD_W; k++) begin
        if (mplier[k]) begin
          acc = (acc + mcand) & mask;
          acc = reduce_once(acc, modulus, mask);
        end
        // Doubling drops the old overflow bit and keeps the new one
        mcand = (mcand << 1) & mask;
        mcand = reduce_once(mcand, modulus, mask);
      end
      for (int i = 0; i < n; i++) begin
        e.product_word = acc[i*WORD_W +: WORD_W];
        e.product_last = (i == n - 1);
        expected_limbs.push_back(e);
      end
      loaded = 0;
    endfunction

    // Compare one result transfer with the oldest expected limb
    function void check_limb(imm_pkg::out_item_t got);
      imm_pkg::out_item_t exp_limb;
      if (expected_limbs.size() == 0) begin
        $display("%0t: unexpected result, actual word %h last %b",
                 $time, got.product_word, got.product_last);
        mismatches++;
        return;
      end
      exp_limb = expected_limbs.pop_front();
      if (got.product_word !== exp_limb.product_word) begin
        $display("%0t: product_word mismatch, expected %h, actual %h",
                 $time, exp_limb.product_word, got.product_word);
        mismatches++;
      end
      if (got.product_last !== exp_limb.product_last) begin
        $display("%0t: product_last mismatch, expected %b, actual %b",
                 $time, exp_limb.product_last, got.product_last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  imm_pkg::in_item_t item_drv = '0;
  logic product_valid;
  imm_pkg::out_item_t product;

  mod_product_tracker tracker = new();
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;

  interleaved_modular_multiplier_unit uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .item_i         (item_drv),
    .product_valid_o(product_valid),
    .product_o      (product)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watch both channels and feed the tracker
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      tracker.note_limb(item_drv);
    end
    if (rst_n && product_valid) begin
      tracker.check_limb(product);
    end
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("interleaved_modular_multiplier_unit test failed");
      $finish;
    end
  end

  // Present one limb, idling first at the given rate, and hold until transfer
  task automatic send_limb(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b,
                           input logic [WORD_W-1:0] m, input logic last,
                           input int idle_pct);
    imm_pkg::in_item_t it;
    it.a_word = a;
    it.b_word = b;
    it.modulus_word = m;
    it.final_limb = last;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item_drv <= it;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // Drop start and hold until every expected limb has come back
  task automatic wait_drained();
    start <= 1'b0;
    // Let the monitor note the last transfer before looking at the queue
    @(posedge clk);
    while (tracker.expected_limbs.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Send one operation of count limbs with operands of a random shape
  task automatic random_op(input int unsigned count, input int idle_pct);
    logic [WORD_W-1:0] a_l [0:LIMB_MAX+7];
    logic [WORD_W-1:0] b_l [0:LIMB_MAX+7];
    logic [WORD_W-1:0] m_l [0:LIMB_MAX+7];
    operand_shape_e shape;
    int unsigned top;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 75) begin
      shape = OPS_BELOW_MOD;
    end else if (pick < 85) begin
      shape = OPS_RAW;
    end else if (pick < 92) begin
      shape = OPS_ZERO_MOD;
    end else begin
      shape = OPS_ALL_ONES;
    end
    top = ((count > LIMB_MAX) ? LIMB_MAX : count) - 1;
    for (int i = 0; i < count; i++) begin
      a_l[i] = $urandom;
      b_l[i] = $urandom;
      m_l[i] = $urandom;
    end
    case (shape)
      OPS_BELOW_MOD: begin
        // Keep both operands below the modulus through the top limb
        m_l[top] = $urandom_range(32'hFFFF_FFFF, 1);
        a_l[top] = $urandom % m_l[top];
        b_l[top] = $urandom % m_l[top];
      end
      OPS_ZERO_MOD: begin
        for (int i = 0; i < count; i++) begin
          m_l[i] = '0;
        end
      end
      OPS_ALL_ONES: begin
        pick = $urandom_range(1);
        for (int i = 0; i < count; i++) begin
          m_l[i] = '1;
          if (pick != 0) begin
            a_l[i] = '1;
            b_l[i] = '1;
          end
        end
      end
      default: begin
      end
    endcase
    for (int i = 0; i < count; i++) begin
      send_limb(a_l[i], b_l[i], m_l[i], (i == count - 1), idle_pct);
    end
  endtask

  // Send mostly short operations until the item count reaches target
  task automatic fill_phase(input int unsigned target, input int idle_pct);
    int unsigned count;
    while (items_sent < target) begin
      count = ($urandom_range(99) < 70) ? $urandom_range(3, 1) : $urandom_range(8, 4);
      random_op(count, idle_pct);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single limbs: all zero, operands equal to an all-ones modulus,
    // largest reduced operands, modulus of one
    send_limb('0, '0, '0, 1'b1, 0);
    send_limb('1, '1, '1, 1'b1, 0);
    send_limb(32'hFFFF_FFFE, 32'hFFFF_FFFE, '1, 1'b1, 0);
    send_limb(32'd5, 32'd7, 32'd1, 1'b1, 0);

    // Zero modulus gives the product modulo the operand width
    send_limb($urandom, $urandom, '0, 1'b0, 0);
    send_limb($urandom, $urandom, '0, 1'b1, 0);

    // Operands one below an all-ones modulus
    send_limb(32'hFFFF_FFFE, 32'hFFFF_FFFE, '1, 1'b0, 0);
    send_limb('1, '1, '1, 1'b1, 0);

    // Carries and borrows that cross every limb
    send_limb('0, '0, 32'd1, 1'b0, 0);
    send_limb('0, '0, '0, 1'b0, 0);
    send_limb(32'd1, 32'd1, 32'd1, 1'b1, 0);

    // Multiplicand equal to the modulus, so doubling overflows the top limb
    send_limb('1, 32'h8000_0000, '1, 1'b0, 0);
    send_limb('1, 32'h8000_0000, '1, 1'b1, 0);

    // Modulus with only the top bit set in its top limb
    send_limb($urandom, $urandom, $urandom, 1'b0, 0);
    send_limb($urandom, $urandom, $urandom, 1'b0, 0);
    send_limb($urandom, $urandom, $urandom, 1'b0, 0);
    send_limb(32'h7FFF_FFFF, 32'h1234_5678, 32'h8000_0000, 1'b1, 0);
    wait_drained();

    // Sender idles often at first, with one full-length operation
    random_op(LIMB_MAX, 21);
    fill_phase(75, 21);
    wait_drained();

    // Idle most of the time, including one load past the limb capacity
    random_op(LIMB_MAX + 3, 81);
    fill_phase(130, 81);
    wait_drained();

    // Back-to-back transfers
    fill_phase(182, 0);

    wait_drained();
    repeat (40) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("interleaved_modular_multiplier_unit test passed");
    end else begin
      $display("interleaved_modular_multiplier_unit test failed");
    end
    $finish;
  end

endmodule
